FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh: assertion shorthands shared by the RTL
// Same-cycle and next-cycle implications, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LLI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// next-cycle implication, disabled while reset is asserted
`define LLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

FILE: rtl/lli_pkg.sv
// ----------------------------------------------------------------------------
// lli_pkg: shared constants for the line intersection pipeline
// Default widths, output format and pipeline latencies.
// ----------------------------------------------------------------------------
`default_nettype none

package lli_pkg;
	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 8;
	localparam int OUT_W      = 32;
	// diffs, products, C/det, numerator products, numerators
	localparam int FRONT_LAT  = 5;
	// operand prep, overflow check, one stage per quotient bit, clamp
	localparam int DIV_LAT    = OUT_W + 3;
endpackage

`default_nettype wire

FILE: rtl/lli_in_if.sv
// ----------------------------------------------------------------------------
// lli_in_if: input channel carrying one pair of lines
// Valid/ready handshake with the eight endpoint coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

interface lli_in_if #(
	parameter int COORD_BITS = lli_pkg::COORD_BITS
) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] line_a_start_x;
	logic signed [COORD_BITS-1:0] line_a_start_y;
	logic signed [COORD_BITS-1:0] line_a_end_x;
	logic signed [COORD_BITS-1:0] line_a_end_y;
	logic signed [COORD_BITS-1:0] line_b_start_x;
	logic signed [COORD_BITS-1:0] line_b_start_y;
	logic signed [COORD_BITS-1:0] line_b_end_x;
	logic signed [COORD_BITS-1:0] line_b_end_y;

	modport source (
		output valid, line_a_start_x, line_a_start_y, line_a_end_x, line_a_end_y,
		       line_b_start_x, line_b_start_y, line_b_end_x, line_b_end_y,
		input  ready
	);
	modport sink (
		input  valid, line_a_start_x, line_a_start_y, line_a_end_x, line_a_end_y,
		       line_b_start_x, line_b_start_y, line_b_end_x, line_b_end_y,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/lli_out_if.sv
// ----------------------------------------------------------------------------
// lli_out_if: result channel carrying one intersection point
// Valid/ready handshake with the Q-format point and status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface lli_out_if ();
	logic                            valid;
	logic                            ready;
	logic signed [lli_pkg::OUT_W-1:0] cross_x;
	logic signed [lli_pkg::OUT_W-1:0] cross_y;
	logic                            lines_parallel;
	logic                            result_saturated;

	modport source (
		output valid, cross_x, cross_y, lines_parallel, result_saturated,
		input  ready
	);
	modport sink (
		input  valid, cross_x, cross_y, lines_parallel, result_saturated,
		output ready
	);
endinterface

`default_nettype wire

FILE: rtl/lli_geom.sv
// ----------------------------------------------------------------------------
// lli_geom: line equations, determinant and Cramer numerators
// Five register stages; every multiply result is registered before use.
// ----------------------------------------------------------------------------
`default_nettype none

module lli_geom #(
	parameter int COORD_BITS = lli_pkg::COORD_BITS
) (
	input  wire logic                              clk,
	input  wire logic                              en,
	input  wire logic signed [COORD_BITS-1:0]      ax1,
	input  wire logic signed [COORD_BITS-1:0]      ay1,
	input  wire logic signed [COORD_BITS-1:0]      ax2,
	input  wire logic signed [COORD_BITS-1:0]      ay2,
	input  wire logic signed [COORD_BITS-1:0]      bx1,
	input  wire logic signed [COORD_BITS-1:0]      by1,
	input  wire logic signed [COORD_BITS-1:0]      bx2,
	input  wire logic signed [COORD_BITS-1:0]      by2,
	output logic signed [3*COORD_BITS+3:0]         numx,
	output logic signed [3*COORD_BITS+3:0]         numy,
	output logic signed [2*COORD_BITS+2:0]         det
);
	localparam int DW = COORD_BITS + 1;     // A, B
	localparam int PW = 2*COORD_BITS + 1;   // A*x
	localparam int CW = 2*COORD_BITS + 2;   // C, A*B
	localparam int TW = 2*COORD_BITS + 3;   // det
	localparam int MW = 3*COORD_BITS + 3;   // B*C
	localparam int NW = 3*COORD_BITS + 4;   // numerators

	// stage 1: line coefficients
	logic signed [DW-1:0]         a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [COORD_BITS-1:0] ax1_s1, ay1_s1, bx1_s1, by1_s1;
	// stage 2: products
	logic signed [PW-1:0]         p_ax_s2, p_by_s2, p_bx_s2, p_b2y_s2;
	logic signed [CW-1:0]         p_ab_s2, p_ba_s2;
	logic signed [DW-1:0]         a1_s2, b1_s2, a2_s2, b2_s2;
	// stage 3: C terms and determinant
	logic signed [CW-1:0]         c1_s3, c2_s3;
	logic signed [TW-1:0]         det_s3;
	logic signed [DW-1:0]         a1_s3, b1_s3, a2_s3, b2_s3;
	// stage 4: numerator products
	logic signed [MW-1:0]         m_b2c1_s4, m_b1c2_s4, m_a1c2_s4, m_a2c1_s4;
	logic signed [TW-1:0]         det_s4;
	// stage 5: numerators
	logic signed [NW-1:0]         numx_s5, numy_s5;
	logic signed [TW-1:0]         det_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			a1_s1  <= DW'(ay2) - DW'(ay1);
			b1_s1  <= DW'(ax1) - DW'(ax2);
			a2_s1  <= DW'(by2) - DW'(by1);
			b2_s1  <= DW'(bx1) - DW'(bx2);
			ax1_s1 <= ax1;
			ay1_s1 <= ay1;
			bx1_s1 <= bx1;
			by1_s1 <= by1;

			p_ax_s2  <= PW'(a1_s1) * PW'(ax1_s1);
			p_by_s2  <= PW'(b1_s1) * PW'(ay1_s1);
			p_bx_s2  <= PW'(a2_s1) * PW'(bx1_s1);
			p_b2y_s2 <= PW'(b2_s1) * PW'(by1_s1);
			p_ab_s2  <= CW'(a1_s1) * CW'(b2_s1);
			p_ba_s2  <= CW'(a2_s1) * CW'(b1_s1);
			a1_s2    <= a1_s1;
			b1_s2    <= b1_s1;
			a2_s2    <= a2_s1;
			b2_s2    <= b2_s1;

			c1_s3  <= CW'(p_ax_s2) + CW'(p_by_s2);
			c2_s3  <= CW'(p_bx_s2) + CW'(p_b2y_s2);
			det_s3 <= TW'(p_ab_s2) - TW'(p_ba_s2);
			a1_s3  <= a1_s2;
			b1_s3  <= b1_s2;
			a2_s3  <= a2_s2;
			b2_s3  <= b2_s2;

			m_b2c1_s4 <= MW'(b2_s3) * MW'(c1_s3);
			m_b1c2_s4 <= MW'(b1_s3) * MW'(c2_s3);
			m_a1c2_s4 <= MW'(a1_s3) * MW'(c2_s3);
			m_a2c1_s4 <= MW'(a2_s3) * MW'(c1_s3);
			det_s4    <= det_s3;

			numx_s5 <= NW'(m_b2c1_s4) - NW'(m_b1c2_s4);
			numy_s5 <= NW'(m_a1c2_s4) - NW'(m_a2c1_s4);
			det_s5  <= det_s4;
		end
	end

	assign numx = numx_s5;
	assign numy = numy_s5;
	assign det  = det_s5;
endmodule

`default_nettype wire

FILE: rtl/lli_div.sv
// ----------------------------------------------------------------------------
// lli_div: pipelined signed fixed-point divider with 32-bit saturation
// Restoring division, one quotient bit per stage, truncation toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lli_div #(
	parameter int COORD_BITS = lli_pkg::COORD_BITS,
	parameter int FRAC_BITS  = lli_pkg::FRAC_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            en,
	input  wire logic signed [3*COORD_BITS+3:0]  num,
	input  wire logic signed [2*COORD_BITS+2:0]  den,
	output logic signed [lli_pkg::OUT_W-1:0]     quo,
	output logic                                 sat
);
	localparam int QW   = lli_pkg::OUT_W;
	localparam int NUMW = 3*COORD_BITS + 4;
	localparam int DENW = 2*COORD_BITS + 3;
	localparam int SW   = NUMW + FRAC_BITS;
	localparam int RW   = ((SW > DENW + QW) ? SW : DENW + QW) + 1;

	logic [NUMW-1:0] nmag;
	logic [DENW-1:0] dmag;

	logic [RW-1:0]   n_sa;
	logic [DENW-1:0] d_sa;
	logic            neg_sa;

	logic [RW-1:0]   rem_s [0:QW];
	logic [QW-1:0]   quot_s [0:QW];
	logic [DENW-1:0] d_s [0:QW];
	logic            neg_s [0:QW];
	logic            ovf_s [0:QW];

	logic [QW-1:0]   lim;
	logic            big;
	logic [QW-1:0]   mag;
	logic [QW-1:0]   quo_sz;
	logic            sat_sz;

	assign nmag = num[NUMW-1] ? (~num + 1'b1) : num;
	assign dmag = den[DENW-1] ? (~den + 1'b1) : den;

	// magnitudes and result sign
	always_ff @(posedge clk) begin
		if (en) begin
			n_sa   <= RW'(nmag) << FRAC_BITS;
			d_sa   <= dmag;
			neg_sa <= num[NUMW-1] ^ den[DENW-1];
		end
	end

	// quotient at or beyond 2^QW clamps regardless of the low bits
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= n_sa;
			quot_s[0] <= '0;
			d_s[0]    <= d_sa;
			neg_s[0]  <= neg_sa;
			ovf_s[0]  <= (n_sa >= (RW'(d_sa) << QW));
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_bit
		logic [RW-1:0] shd;
		logic          ge;
		assign shd = RW'(d_s[k]) << (QW - 1 - k);
		assign ge  = (rem_s[k] >= shd);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? (rem_s[k] - shd) : rem_s[k];
				quot_s[k+1] <= {quot_s[k][QW-2:0], ge};
				d_s[k+1]    <= d_s[k];
				neg_s[k+1]  <= neg_s[k];
				ovf_s[k+1]  <= ovf_s[k];
			end
		end
	end

	// clamp to 2^31 for negative results, 2^31-1 for positive ones
	assign lim    = {neg_s[QW], {(QW-1){~neg_s[QW]}}};
	assign big    = ovf_s[QW] || (quot_s[QW] > lim);
	assign mag    = big ? lim : quot_s[QW];
	assign quo_sz = neg_s[QW] ? (~mag + 1'b1) : mag;
	assign sat_sz = big;

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= quo_sz;
			sat <= sat_sz;
		end
	end

	// d_s/rem_s at the last stage feed nothing further
	logic unused_tail;
	assign unused_tail = ^{rem_s[QW], d_s[QW]};
endmodule

`default_nettype wire

FILE: rtl/line_line_intersection.sv
// ----------------------------------------------------------------------------
// line_line_intersection: two-line intersection by Cramer's rule
// Pipelined geometry front end followed by two parallel divider lanes.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out, one per clock when the result side
// keeps ready high. The pipeline is laid out as follows at the default
// 32-bit output: five stages form the line coefficients, the determinant and
// the two numerators, then each coordinate passes a restoring divider that
// retires one quotient bit per stage, bracketed by an operand stage, an
// overflow stage and a clamp stage. The whole pipeline advances on one enable:
// it moves whenever the last stage is empty or its result is being taken, so
// an empty output stage never blocks the input, while a stall holds every
// stage in place, empty slots included. Results are
// signed Q(32-FRAC_BITS).FRAC_BITS, truncated toward zero; parallel or
// degenerate lines report (0,0) with lines_parallel set, and a coordinate out
// of 32-bit range clamps and sets result_saturated. No state survives an item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module line_line_intersection #(
	parameter int COORD_BITS = lli_pkg::COORD_BITS,
	parameter int FRAC_BITS  = lli_pkg::FRAC_BITS
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lli_in_if.sink    pairs,
	lli_out_if.source hits
);
	localparam int TOT  = lli_pkg::FRONT_LAT + lli_pkg::DIV_LAT;
	localparam int NUMW = 3*COORD_BITS + 4;
	localparam int DENW = 2*COORD_BITS + 3;
	localparam int QW   = lli_pkg::OUT_W;

	logic                   en;
	logic                   take;
	logic [TOT-1:0]         vld_s;
	logic [lli_pkg::DIV_LAT-1:0] par_s;

	logic signed [NUMW-1:0] numx, numy;
	logic signed [DENW-1:0] det;
	logic signed [QW-1:0]   qx, qy;
	logic                   satx, saty;

	// advance when the output stage is empty or being drained
	assign en          = hits.ready || !vld_s[TOT-1];
	assign pairs.ready = en;
	assign take        = pairs.valid && pairs.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[TOT-2:0], take};
		end
	end

	lli_geom #(
		.COORD_BITS(COORD_BITS)
	) u_geom (
		.clk  (clk),
		.en   (en),
		.ax1  (pairs.line_a_start_x),
		.ay1  (pairs.line_a_start_y),
		.ax2  (pairs.line_a_end_x),
		.ay2  (pairs.line_a_end_y),
		.bx1  (pairs.line_b_start_x),
		.by1  (pairs.line_b_start_y),
		.bx2  (pairs.line_b_end_x),
		.by2  (pairs.line_b_end_y),
		.numx (numx),
		.numy (numy),
		.det  (det)
	);

	// carry the parallel flag alongside the divider lanes
	always_ff @(posedge clk) begin
		if (en) begin
			par_s <= {par_s[lli_pkg::DIV_LAT-2:0], (det == '0)};
		end
	end

	lli_div #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_div_x (
		.clk (clk),
		.en  (en),
		.num (numx),
		.den (det),
		.quo (qx),
		.sat (satx)
	);

	lli_div #(
		.COORD_BITS(COORD_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_div_y (
		.clk (clk),
		.en  (en),
		.num (numy),
		.den (det),
		.quo (qy),
		.sat (saty)
	);

	// parallel lines override whatever the dividers produced for a zero divisor
	assign hits.valid            = vld_s[TOT-1];
	assign hits.lines_parallel   = par_s[lli_pkg::DIV_LAT-1];
	assign hits.cross_x          = par_s[lli_pkg::DIV_LAT-1] ? '0 : qx;
	assign hits.cross_y          = par_s[lli_pkg::DIV_LAT-1] ? '0 : qy;
	assign hits.result_saturated = !par_s[lli_pkg::DIV_LAT-1] && (satx || saty);

	`LLI_ASSERT_NEXT(a_take_enters, clk, arst_n, take, vld_s[0])
	`LLI_ASSERT_NEXT(a_stall_holds, clk, arst_n, !en, $stable(vld_s))
	`LLI_ASSERT_NOW(a_sat_at_bound, clk, arst_n,
		hits.valid && hits.result_saturated,
		(hits.cross_x == 32'sh7fffffff) || (hits.cross_x == 32'sh80000000) ||
		(hits.cross_y == 32'sh7fffffff) || (hits.cross_y == 32'sh80000000))
endmodule

`default_nettype wire
